// ----- rtl/core/apts_pkg.sv -----
// Shared types and constants for the aging priority task scheduler.
// Used by apts_ctrl, apts_datapath and the aging_priority_task_scheduler top level.
package apts_pkg;

  localparam int NUM_TASKS_DEF = 16;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_SET    = 3'd1,
    OP_PICK   = 3'd2,
    OP_FINISH = 3'd3,
    OP_GET    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_UNKNOWN = 2'd3
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APPLY,
    S_SHIFT,
    S_DONE
  } state_t;

  // One row of the ready table.
  typedef struct packed {
    logic [7:0] id;
    logic [5:0] sprio;
    logic [7:0] dprio;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic sweep_init;
    logic scan;
    logic apply;
    logic shift;
    logic dec_count;
    logic publish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t  op;
    logic empty;
    logic found;
    logic term;
    logic sweep_done;
    logic out_busy;
  } stat_t;

endpackage

// ----- rtl/core/apts_ctrl.sv -----
// Sequencing state machine of the aging priority task scheduler.
// Depends on apts_pkg; drives the command struct of apts_datapath.
module apts_ctrl import apts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_PICK:                  state_next = stat.empty ? S_APPLY : S_SCAN;
          OP_SET, OP_GET, OP_FINISH: state_next = S_SCAN;
          default:                  state_next = S_APPLY;
        endcase
      end
      S_SCAN: begin
        if (stat.sweep_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        if (stat.op == OP_FINISH && stat.found && stat.term) state_next = S_SHIFT;
        else state_next = S_DONE;
      end
      S_SHIFT: begin
        if (stat.sweep_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = (state != S_IDLE);
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.sweep_init = (state == S_DECODE);
    cmd.scan       = (state == S_SCAN);
    cmd.apply      = (state == S_APPLY);
    cmd.shift      = (state == S_SHIFT);
    cmd.dec_count  = (state == S_SHIFT) && stat.sweep_done;
    cmd.publish    = (state == S_DONE) && !stat.out_busy;
  end

endmodule

// ----- rtl/core/apts_datapath.sv -----
// Ready table memory, sweep pipeline, counters and result registers.
// Depends on apts_pkg; sequenced by apts_ctrl through cmd_t and stat_t.
module apts_datapath import apts_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  opcode,
  input  logic [7:0]  task_id,
  input  logic [5:0]  prio,
  input  logic        terminated,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  status,
  output logic [7:0]  result_id,
  output logic [5:0]  result_prio,
  output logic [4:0]  tasks_left
);

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam int CNT_W = $clog2(NUM_TASKS + 1);

  entry_t mem [NUM_TASKS];
  entry_t rdata;

  logic [CNT_W-1:0] task_count;
  logic [CNT_W-1:0] rd_idx;
  logic [7:0]       next_id;
  logic [3:0]       aging_step;

  op_t        op_q;
  logic [7:0] tid_q;
  logic [5:0] prio_q;
  logic       term_q;

  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_ent;
  logic [IDX_W-1:0] best_idx;
  entry_t           best_ent;

  st_t        res_status;
  logic [7:0] res_id;
  logic [5:0] res_prio;

  logic             full, empty, rd_issue;
  logic [8:0]       diff;
  logic [7:0]       aged;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  assign full     = (task_count >= CNT_W'(NUM_TASKS));
  assign empty    = (task_count == '0);
  assign rd_issue = (cmd.scan || cmd.shift) && (rd_idx < task_count);

  // Aging with saturation at -128: the nine-bit difference is below -128
  // exactly when its top two bits read 10.
  assign diff = {rdata.dprio[7], rdata.dprio} - {5'b0, aging_step};
  assign aged = (diff[8] && !diff[7]) ? 8'h80 : diff[7:0];

  always_comb begin
    stat.op         = op_q;
    stat.empty      = empty;
    stat.found      = found;
    stat.term       = term_q;
    stat.sweep_done = !pend && !(rd_idx < task_count);
    stat.out_busy   = out_valid && out_stall;
  end

  // Single write port shared by the aging sweep, the close-up shift and the
  // final update of each operation.
  always_comb begin
    we    = 1'b0;
    waddr = pend_idx;
    wdata = rdata;
    if (cmd.scan && pend && op_q == OP_PICK) begin
      we          = 1'b1;
      wdata.dprio = aged;
    end else if (cmd.shift && pend) begin
      we    = 1'b1;
      waddr = pend_idx - IDX_W'(1);
    end else if (cmd.apply) begin
      unique case (op_q)
        OP_CREATE: begin
          we    = !full;
          waddr = task_count[IDX_W-1:0];
          wdata = '{id: next_id, sprio: 6'd0, dprio: 8'd0};
        end
        OP_PICK: begin
          // The winner was aged with the rest; put back its original value.
          we    = !empty;
          waddr = best_idx;
          wdata = best_ent;
        end
        OP_SET: begin
          we    = found;
          waddr = hit_idx;
          wdata = '{id: hit_ent.id, sprio: prio_q, dprio: {{2{prio_q[5]}}, prio_q}};
        end
        OP_FINISH: begin
          we    = found && !term_q;
          waddr = hit_idx;
          wdata = '{id: hit_ent.id, sprio: hit_ent.sprio,
                    dprio: {{2{hit_ent.sprio[5]}}, hit_ent.sprio}};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_issue) rdata <= mem[rd_idx[IDX_W-1:0]];
  end

  // Operand capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(opcode);
      tid_q  <= task_id;
      prio_q <= prio;
      term_q <= terminated;
    end
    if (cmd.scan && pend) begin
      if (op_q == OP_PICK) begin
        if (pend_idx == '0 || $signed(rdata.dprio) < $signed(best_ent.dprio)) begin
          best_idx <= pend_idx;
          best_ent <= rdata;
        end
      end else if (!found && rdata.id == tid_q) begin
        hit_idx <= pend_idx;
        hit_ent <= rdata;
      end
    end
    if (rd_issue) pend_idx <= rd_idx[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      found  <= 1'b0;
    end else begin
      pend <= rd_issue;
      if (rd_issue) rd_idx <= rd_idx + CNT_W'(1);
      if (cmd.sweep_init) begin
        rd_idx <= '0;
        found  <= 1'b0;
      end else if (cmd.scan && pend && op_q != OP_PICK && rdata.id == tid_q) begin
        found <= 1'b1;
      end
      // A removal closes up the order from the entry after the hit.
      if (cmd.apply && op_q == OP_FINISH && found && term_q) begin
        rd_idx <= CNT_W'(hit_idx) + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      next_id    <= 8'd0;
    end else begin
      if (cmd.apply && op_q == OP_CREATE && !full) begin
        task_count <= task_count + CNT_W'(1);
        next_id    <= next_id + 8'd1;
      end
      if (cmd.dec_count) task_count <= task_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aging_step <= 4'd1;
    end else if (cfg_wr_en) begin
      aging_step <= cfg_wr_data;
    end
  end

  // Result of the operation, held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_status <= ST_OK;
      res_id     <= 8'd0;
      res_prio   <= 6'd0;
      unique case (op_q)
        OP_CREATE: begin
          if (full) res_status <= ST_FULL;
          else res_id <= next_id;
        end
        OP_PICK: begin
          if (empty) res_status <= ST_EMPTY;
          else res_id <= best_ent.id;
        end
        OP_SET, OP_FINISH: begin
          if (!found) res_status <= ST_UNKNOWN;
        end
        OP_GET: begin
          if (!found) res_status <= ST_UNKNOWN;
          else res_prio <= hit_ent.sprio;
        end
        default: res_status <= ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status      <= res_status;
      result_id   <= res_id;
      result_prio <= res_prio;
      tasks_left  <= 5'(task_count);
    end
  end

endmodule

// ----- rtl/core/aging_priority_task_scheduler.sv -----
// Top level of the aging priority task scheduler: controller plus datapath.
// Depends on apts_pkg, apts_ctrl and apts_datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    opcode, task_id, prio, terminated
//   out      output     out_valid / out_stall  status, result_id, result_prio, tasks_left
//   cfg      input      cfg_wr_en              cfg_wr_data (aging step)
//
// One operation at a time. Create, pick on an empty table and unused opcodes go
// straight from decode to the update; pick, set, get and finish first sweep the table
// through its single read port, and a terminating finish that finds its task adds
// a further pass over the entries after it to close up the order.
// Reset (rst, synchronous) empties the table, zeroes the id counter and sets the
// aging step to 1; no clearing pass is needed. A new item is taken while the
// previous result still waits on out_stall; its own result then waits for that one.
module aging_priority_task_scheduler import apts_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [7:0] task_id,
  input  logic [5:0] prio,
  input  logic       terminated,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] result_id,
  output logic [5:0] result_prio,
  output logic [4:0] tasks_left,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  apts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  apts_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .task_id     (task_id),
    .prio        (prio),
    .terminated  (terminated),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .result_id   (result_id),
    .result_prio (result_prio),
    .tasks_left  (tasks_left)
  );

endmodule
